>>> rtl/ssdab_pkg.sv
// ----------------------------------------------------------------------------
// ssdab_pkg
// Shared constants, types and small helpers for the anchor box decoder.
// ----------------------------------------------------------------------------
package ssdab_pkg;

  localparam int ANCHORS_PER_FRAME = 3584;
  localparam logic [2:0] LAST_LAYER = 3'd5;
  localparam logic [12:0] MAX_FRAME = 13'd4096;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_LOGIT_THRESHOLD = 2'd2;

  // per-axis operands handed to the axis datapath
  typedef struct packed {
    logic signed [15:0] offset;
    logic signed [15:0] size;
    logic [4:0]         grid_pos;
    logic [2:0]         grid_log;
    logic [12:0]        frame;
  } axis_in_t;

  // log2 of the grid side for a layer (strides 8, 16, then 32 on a 256 grid)
  function automatic logic [2:0] grid_log(input logic [2:0] layer);
    logic [2:0] r;
    case (layer)
      3'd0:    r = 3'd5;
      3'd1:    r = 3'd4;
      default: r = 3'd3;
    endcase
    return r;
  endfunction

  // anchors per cell for a layer
  function automatic logic [2:0] slot_count(input logic [2:0] layer);
    logic [2:0] r;
    case (layer)
      3'd0, 3'd1: r = 3'd2;
      default:    r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] clamp_frame(input logic [12:0] f);
    return (f > MAX_FRAME) ? MAX_FRAME : f;
  endfunction

endpackage

>>> rtl/ssdab_axis.sv
// ----------------------------------------------------------------------------
// ssdab_axis
// One axis of the box decode: expand, scale to the frame, clip to frame.
// ----------------------------------------------------------------------------
module ssdab_axis (
  input  ssdab_pkg::axis_in_t axis_in,
  output logic [11:0]         lo,
  output logic [12:0]         len,
  output logic                ok
);

  logic signed [18:0] size_x;
  logic signed [18:0] size7;
  logic signed [13:0] frame_s;
  logic signed [25:0] off_sh;
  logic signed [25:0] base;
  logic signed [25:0] size_sh;
  logic signed [25:0] num;
  logic signed [32:0] ext_prod;
  logic signed [39:0] start_prod;

  logic signed [32:0] ext_adj;
  logic [4:0]         start_sh;
  logic signed [39:0] start_mask;
  logic signed [39:0] start_adj;
  logic signed [39:0] start_full;
  logic signed [23:0] ext24;
  logic signed [23:0] start24;
  logic signed [23:0] frame24;
  logic signed [23:0] a;
  logic signed [23:0] b;
  logic signed [23:0] b_clip;
  logic signed [23:0] span;

  // edge numerator: 4*d*g + 8192*(2*cell+1) - 7*size*g, g a power of two;
  // divide by powers of two, truncating toward zero, then clip to [0, frame)
  always_comb begin
    size_x     = 19'(axis_in.size);
    size7      = (size_x <<< 3) - size_x;
    frame_s    = signed'({1'b0, axis_in.frame});
    off_sh     = 26'(axis_in.offset) <<< (axis_in.grid_log + 3'd2);
    base       = signed'(26'({axis_in.grid_pos, 1'b1, 13'b0}));
    size_sh    = 26'(size7) <<< axis_in.grid_log;
    num        = off_sh + base - size_sh;
    ext_prod   = 33'(size7) * 33'(frame_s);
    start_prod = 40'(num) * 40'(frame_s);

    ext_adj    = ext_prod + (ext_prod[32] ? 33'sd8191 : 33'sd0);
    start_sh   = 5'(axis_in.grid_log) + 5'd14;
    start_mask = (40'sd1 <<< start_sh) - 40'sd1;
    start_adj  = start_prod + (start_prod[39] ? start_mask : 40'sd0);
    start_full = start_adj >>> start_sh;
    ext24      = 24'(signed'(ext_adj[32:13]));
    start24    = 24'(signed'(start_full[22:0]));
    frame24    = signed'(24'(axis_in.frame));
    a          = start24[23] ? 24'sd0 : start24;
    b          = start24 + ext24;
    b_clip     = (b > frame24) ? frame24 : b;
    span       = b_clip - a;
    ok         = (ext24 > 24'sd0) && (b_clip > a);
    lo         = a[11:0];
    len        = span[12:0];
  end

endmodule

>>> rtl/ssd_anchor_box_decoder_core.sv
// ----------------------------------------------------------------------------
// ssd_anchor_box_decoder_core
// Decodes one detector word per anchor into a clipped frame-pixel box.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one anchor word: frame_start,
//   anchor_score and four box offsets (x/y in Q4.12). Anchor positions come from internal
//   counters; frame_start restarts them so that word is anchor zero.
//   Output channel (out_valid/out_ready) carries a box only for anchors whose
//   score is above logit_threshold and whose clipped box is non-empty; other
//   anchors give no word.
//   Configuration: cfg_write with cfg_index/cfg_data; write only while no word
//   is in flight.
//   Pipeline: an accepted word enters the input register, then its box the result
//   register. One word is accepted every cycle unless both registers hold a word;
//   the decode sits in one pass between the two registers.
//   When the receiver stalls, both registers hold their word; a bubble still
//   closes up, so in_ready falls only once both are full.
//   Reset clears the counters and valids, frame size to 640x480 and the
//   threshold to zero.
// ----------------------------------------------------------------------------
module ssd_anchor_box_decoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               frame_start,
  input  logic signed [15:0] anchor_score,
  input  logic signed [15:0] offset_x,
  input  logic signed [15:0] offset_y,
  input  logic signed [15:0] size_w,
  input  logic signed [15:0] size_h,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        anchor_index,
  output logic [11:0]        box_left,
  output logic [11:0]        box_top,
  output logic [12:0]        box_width,
  output logic [12:0]        box_height,
  output logic signed [15:0] score_logit
);

  logic [12:0]        frame_width;
  logic [12:0]        frame_height;
  logic signed [15:0] logit_threshold;

  logic [11:0] anchor_count;
  logic [2:0]  layer_index;
  logic [4:0]  cell_row;
  logic [4:0]  cell_col;
  logic [2:0]  slot_index;

  logic [11:0] anchor_count_next;
  logic [2:0]  layer_index_next;
  logic [4:0]  cell_row_next;
  logic [4:0]  cell_col_next;
  logic [2:0]  slot_index_next;

  logic [11:0] cur_count;
  logic [2:0]  cur_layer;
  logic [4:0]  cur_row;
  logic [4:0]  cur_col;
  logic [2:0]  cur_slot;
  logic [5:0]  grid_side;
  logic [3:0]  slot_inc;
  logic [5:0]  col_inc;
  logic [5:0]  row_inc;
  logic [12:0] count_inc;

  logic en1, en2;
  logic accept;

  logic               s1_valid;
  logic signed [15:0] s1_score;
  logic signed [15:0] s1_dx;
  logic signed [15:0] s1_dy;
  logic signed [15:0] s1_dw;
  logic signed [15:0] s1_dh;
  logic [4:0]         s1_col;
  logic [4:0]         s1_row;
  logic [2:0]         s1_glog;
  logic [11:0]        s1_idx;

  ssdab_pkg::axis_in_t x_in, y_in;
  logic [11:0] x_lo, y_lo;
  logic [12:0] x_len, y_len;
  logic        x_ok, y_ok;

  // each register advances when its successor has room
  assign en2      = !out_valid || out_ready;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;
  assign accept   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= 13'd640;
      frame_height    <= 13'd480;
      logit_threshold <= 16'sd0;
    end else if (cfg_write) begin
      case (cfg_index)
        ssdab_pkg::REG_FRAME_WIDTH:     frame_width     <= cfg_data[12:0];
        ssdab_pkg::REG_FRAME_HEIGHT:    frame_height    <= cfg_data[12:0];
        ssdab_pkg::REG_LOGIT_THRESHOLD: logit_threshold <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // anchor walk: slot, column, row, layer; wrap all at end of frame
  always_comb begin
    cur_count = frame_start ? 12'd0 : anchor_count;
    cur_layer = frame_start ? 3'd0  : layer_index;
    cur_row   = frame_start ? 5'd0  : cell_row;
    cur_col   = frame_start ? 5'd0  : cell_col;
    cur_slot  = frame_start ? 3'd0  : slot_index;

    grid_side = 6'd1 << ssdab_pkg::grid_log(cur_layer);
    slot_inc  = {1'b0, cur_slot} + 4'd1;
    col_inc   = {1'b0, cur_col} + 6'd1;
    row_inc   = {1'b0, cur_row} + 6'd1;
    count_inc = {1'b0, cur_count} + 13'd1;

    slot_index_next  = slot_inc[2:0];
    cell_col_next    = cur_col;
    cell_row_next    = cur_row;
    layer_index_next = cur_layer;
    if (slot_inc >= {1'b0, ssdab_pkg::slot_count(cur_layer)}) begin
      slot_index_next = 3'd0;
      cell_col_next   = col_inc[4:0];
      if (col_inc >= grid_side) begin
        cell_col_next = 5'd0;
        cell_row_next = row_inc[4:0];
        if (row_inc >= grid_side) begin
          cell_row_next    = 5'd0;
          layer_index_next = (cur_layer == ssdab_pkg::LAST_LAYER) ? 3'd0
                                                                  : cur_layer + 3'd1;
        end
      end
    end
    anchor_count_next = count_inc[11:0];
    if (count_inc >= 13'(ssdab_pkg::ANCHORS_PER_FRAME)) begin
      anchor_count_next = 12'd0;
      layer_index_next  = 3'd0;
      cell_row_next     = 5'd0;
      cell_col_next     = 5'd0;
      slot_index_next   = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_count <= 12'd0;
      layer_index  <= 3'd0;
      cell_row     <= 5'd0;
      cell_col     <= 5'd0;
      slot_index   <= 3'd0;
    end else if (accept) begin
      anchor_count <= anchor_count_next;
      layer_index  <= layer_index_next;
      cell_row     <= cell_row_next;
      cell_col     <= cell_col_next;
      slot_index   <= slot_index_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_score <= anchor_score;
      s1_dx    <= offset_x;
      s1_dy    <= offset_y;
      s1_dw    <= size_w;
      s1_dh    <= size_h;
      s1_col   <= cur_col;
      s1_row   <= cur_row;
      s1_glog  <= ssdab_pkg::grid_log(cur_layer);
      s1_idx   <= cur_count;
    end
  end

  always_comb begin
    x_in.offset   = s1_dx;
    x_in.size     = s1_dw;
    x_in.grid_pos = s1_col;
    x_in.grid_log = s1_glog;
    x_in.frame    = ssdab_pkg::clamp_frame(frame_width);
    y_in.offset   = s1_dy;
    y_in.size     = s1_dh;
    y_in.grid_pos = s1_row;
    y_in.grid_log = s1_glog;
    y_in.frame    = ssdab_pkg::clamp_frame(frame_height);
  end

  ssdab_axis u_axis_x (
    .axis_in (x_in),
    .lo      (x_lo),
    .len     (x_len),
    .ok      (x_ok)
  );

  ssdab_axis u_axis_y (
    .axis_in (y_in),
    .lo      (y_lo),
    .len     (y_len),
    .ok      (y_ok)
  );

  // result register: drop anchors at or below threshold or with an empty box
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= s1_valid && (s1_score > logit_threshold) && x_ok && y_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      anchor_index <= s1_idx;
      box_left     <= x_lo;
      box_top      <= y_lo;
      box_width    <= x_len;
      box_height   <= y_len;
      score_logit  <= s1_score;
    end
  end

endmodule

>>> tb/ssd_anchor_box_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_anchor_box_decoder_core_tb
// Self-checking bench for the anchor box decoder. An in-bench predictor walks
// the anchor grid and decodes every accepted word; a checker compares each box
// on the output channel, field by field, against the oldest prediction. Both
// channels idle and stall at random; register settings change between phases.
// ----------------------------------------------------------------------------
module ssd_anchor_box_decoder_core_tb;

  localparam int GAP_MAX     = 17;
  localparam int LAYER_TOTAL = 6;
  localparam int MODEL_SIDE  = 256;
  localparam int SETTLE      = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int WALK_WORDS  = 640;

  typedef struct packed {
    logic               start;
    logic signed [15:0] score;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dw;
    logic signed [15:0] dh;
  } anchor_word_t;

  typedef struct packed {
    logic [11:0]        idx;
    logic [11:0]        left;
    logic [11:0]        top;
    logic [12:0]        wid;
    logic [12:0]        hgt;
    logic signed [15:0] score;
  } box_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = ssdab_pkg::REG_FRAME_WIDTH;
  logic [15:0]        cfg_data = 16'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               frame_start = 1'b0;
  logic signed [15:0] anchor_score = 16'sd0;
  logic signed [15:0] offset_x = 16'sd0;
  logic signed [15:0] offset_y = 16'sd0;
  logic signed [15:0] size_w = 16'sd0;
  logic signed [15:0] size_h = 16'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [11:0]        anchor_index;
  logic [11:0]        box_left;
  logic [11:0]        box_top;
  logic [12:0]        box_width;
  logic [12:0]        box_height;
  logic signed [15:0] score_logit;

  ssd_anchor_box_decoder_core i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers and the anchor walk
  logic [12:0]        frame_w = 13'd640;
  logic [12:0]        frame_h = 13'd480;
  logic signed [15:0] keep_thr = 16'sd0;
  int anchor_cnt = 0;
  int layer = 0;
  int row = 0;
  int col = 0;
  int slot = 0;

  box_t boxes_due[$];

  int err_count = 0;
  int words_sent = 0;
  int boxes_seen = 0;
  int frame_wraps = 0;
  int reg_writes = 0;
  int send_gap_max = GAP_MAX;
  int ready_gap_max = GAP_MAX;
  int ready_wait = 0;
  int hold_cycles = 0;

  task automatic report_error(input string what, input longint want_v, input longint got_v);
    if (err_count < 100)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    err_count++;
  endtask

  function automatic int grid_side(input int l);
    int stride;
    case (l)
      0:       stride = 8;
      1:       stride = 16;
      default: stride = 32;
    endcase
    return (MODEL_SIDE + stride - 1) / stride;
  endfunction

  function automatic int slots_per_cell(input int l);
    return (l < 2) ? 2 : 6;
  endfunction

  task automatic restart_walk();
    anchor_cnt = 0;
    layer = 0;
    row = 0;
    col = 0;
    slot = 0;
  endtask

  task automatic step_walk();
    slot++;
    if (slot >= slots_per_cell(layer)) begin
      slot = 0;
      col++;
      if (col >= grid_side(layer)) begin
        col = 0;
        row++;
        if (row >= grid_side(layer)) begin
          row = 0;
          layer = (layer + 1) % LAYER_TOTAL;
        end
      end
    end
    anchor_cnt++;
    if (anchor_cnt >= ssdab_pkg::ANCHORS_PER_FRAME) begin
      restart_walk();
      frame_wraps++;
    end
  endtask

  // one axis: expand, scale to the frame, clip; 0 when nothing is left
  function automatic bit fit_axis(input longint d, input longint sz, input longint pos,
                                  input longint g, input longint frame,
                                  output longint lo, output longint len);
    longint ext, start, a, b;
    lo = 0;
    len = 0;
    if (frame <= 0) return 1'b0;
    ext = (sz * 7 * frame) / 8192;
    start = ((4 * d * g + 8192 * (2 * pos + 1) - 7 * sz * g) * frame) / (16384 * g);
    if (ext <= 0) return 1'b0;
    a = (start < 0) ? 0 : start;
    b = start + ext;
    if (b > frame) b = frame;
    if (b <= a) return 1'b0;
    lo = a;
    len = b - a;
    return 1'b1;
  endfunction

  task automatic predict_box(input anchor_word_t w);
    longint fw, fh, g, lx, wx, ly, hy;
    bit keep;
    box_t b;
    if (w.start) restart_walk();
    g = grid_side(layer);
    fw = (frame_w > ssdab_pkg::MAX_FRAME) ? ssdab_pkg::MAX_FRAME : frame_w;
    fh = (frame_h > ssdab_pkg::MAX_FRAME) ? ssdab_pkg::MAX_FRAME : frame_h;
    keep = $signed(w.score) > keep_thr;
    if (keep)
      keep = fit_axis($signed(w.dx), $signed(w.dw), col, g, fw, lx, wx)
          && fit_axis($signed(w.dy), $signed(w.dh), row, g, fh, ly, hy);
    if (keep) begin
      b.idx   = anchor_cnt[11:0];
      b.left  = 12'(lx);
      b.top   = 12'(ly);
      b.wid   = 13'(wx);
      b.hgt   = 13'(hy);
      b.score = w.score;
      boxes_due = {boxes_due, b};
    end
    step_walk();
  endtask

  function automatic anchor_word_t anchor_word(input bit st, input int sc, input int dx,
                                               input int dy, input int dw, input int dh);
    anchor_word_t w;
    w.start = st;
    w.score = 16'(sc);
    w.dx    = 16'(dx);
    w.dy    = 16'(dy);
    w.dw    = 16'(dw);
    w.dh    = 16'(dh);
    return w;
  endfunction

  // mostly plausible detections around the threshold, the rest raw noise
  function automatic anchor_word_t draw_word();
    anchor_word_t w;
    int s;
    if ($urandom_range(0, 4) == 0) begin
      w.start = ($urandom_range(0, 7) == 0);
      w.score = 16'($urandom);
      w.dx    = 16'($urandom);
      w.dy    = 16'($urandom);
      w.dw    = 16'($urandom);
      w.dh    = 16'($urandom);
    end else begin
      s = int'(keep_thr) + int'($urandom_range(0, 600)) - 200;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      w.start = ($urandom_range(0, 59) == 0);
      w.score = 16'(s);
      w.dx    = 16'(int'($urandom_range(0, 2048)) - 1024);
      w.dy    = 16'(int'($urandom_range(0, 2048)) - 1024);
      w.dw    = 16'(int'($urandom_range(0, 1600)) - 40);
      w.dh    = 16'(int'($urandom_range(0, 1600)) - 40);
    end
    return w;
  endfunction

  task automatic send_word(input anchor_word_t w);
    int gap;
    gap = (send_gap_max > 0) ? int'($urandom_range(0, send_gap_max)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    frame_start  <= w.start;
    anchor_score <= w.score;
    offset_x     <= w.dx;
    offset_y     <= w.dy;
    size_w       <= w.dw;
    size_h       <= w.dh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_box(w);
    words_sent++;
  endtask

  // drop valid, wait for every outstanding box, then let dropped words clear
  task automatic settle();
    int n;
    @(negedge clk);
    in_valid <= 1'b0;
    n = 0;
    while (boxes_due.size() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      ssdab_pkg::REG_FRAME_WIDTH:     frame_w = data[12:0];
      ssdab_pkg::REG_FRAME_HEIGHT:    frame_h = data[12:0];
      ssdab_pkg::REG_LOGIT_THRESHOLD: keep_thr = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_regs(input logic [15:0] w, input logic [15:0] h, input logic [15:0] thr);
    settle();
    write_reg(ssdab_pkg::REG_FRAME_WIDTH, w);
    write_reg(ssdab_pkg::REG_FRAME_HEIGHT, h);
    write_reg(ssdab_pkg::REG_LOGIT_THRESHOLD, thr);
  endtask

  // reset values: threshold edge, clipping, empty boxes, restart mid-frame
  task automatic test_defaults();
    send_word(anchor_word(1, 1, 2048, 2048, 320, 320));
    send_word(anchor_word(0, 0, 2048, 2048, 320, 320));
    send_word(anchor_word(0, -1, 2048, 2048, 320, 320));
    send_word(anchor_word(0, 256, -2048, 0, 400, 400));
    send_word(anchor_word(0, 256, 16000, 16000, 400, 400));
    send_word(anchor_word(0, 256, 2048, 2048, 0, 100));
    send_word(anchor_word(0, 256, 2048, 2048, -100, 100));
    send_word(anchor_word(1, 512, 4000, 4000, 2000, 2000));
    send_word(anchor_word(0, 300, 1000, -1000, 800, 600));
  endtask

  // field and register extremes, empty and oversized frames
  task automatic test_field_extremes();
    set_regs(16'd4096, 16'd4096, 16'h8000);
    send_word(anchor_word(0, -32768, 2048, 2048, 400, 400));
    send_word(anchor_word(0, -32767, 32767, -32768, 32767, 32767));
    send_word(anchor_word(0, 32767, -32768, 32767, 1, 1));
    send_word(anchor_word(0, 32767, 0, 0, -32768, -32768));
    set_regs(16'd8191, 16'd0, 16'd0);
    send_word(anchor_word(0, 256, 2048, 2048, 400, 400));
    set_regs(16'd8191, 16'd8191, 16'h7fff);
    send_word(anchor_word(0, 32767, 2048, 2048, 400, 400));
    set_regs(16'd1, 16'd1, 16'h8000);
    send_word(anchor_word(0, 100, 0, 0, 2000, 2000));
    send_word(anchor_word(1, 32767, 0, 0, 32767, 32767));
  endtask

  // walk the first rows of the finest grid back to back; keep boxes at row edges
  task automatic test_grid_walk();
    anchor_word_t w;
    bit hit;
    set_regs(16'd640, 16'd480, 16'd0);
    send_gap_max = 0;
    ready_gap_max = 3;
    for (int i = 0; i < WALK_WORDS; i++) begin
      hit = (i % 23 == 0) || (i % 64 < 2) || (i % 64 > 61);
      w = anchor_word(i == 0, hit ? 256 : -256,
                      int'($urandom_range(0, 2048)) - 1024,
                      int'($urandom_range(0, 2048)) - 1024,
                      200 + int'($urandom_range(0, 1000)),
                      200 + int'($urandom_range(0, 1000)));
      send_word(w);
    end
    send_gap_max = GAP_MAX;
    ready_gap_max = GAP_MAX;
  endtask

  // hold the receiver off while words keep coming, so the input stalls
  task automatic test_backpressure();
    set_regs(16'd640, 16'd480, 16'd0);
    send_gap_max = 0;
    hold_cycles = 150;
    for (int i = 0; i < 40; i++)
      send_word(anchor_word(i == 0, 100 + int'($urandom_range(0, 3000)),
                            0, 0, 400 + int'($urandom_range(0, 400)),
                            400 + int'($urandom_range(0, 400))));
    send_gap_max = GAP_MAX;
    settle();
  endtask

  task automatic test_random();
    int count;
    for (int p = 0; p < 7; p++) begin
      count = 120;
      case (p)
        0: begin
          set_regs(16'd640, 16'd480, 16'd0);
          send_gap_max = GAP_MAX; ready_gap_max = GAP_MAX;
        end
        1: begin
          set_regs(16'd4096, 16'd4096, 16'(int'($urandom_range(0, 1024)) - 512));
          send_gap_max = 0; ready_gap_max = 0;
        end
        2: begin
          set_regs(16'd1, 16'd1, 16'h8000);
          send_gap_max = GAP_MAX; ready_gap_max = 0;
        end
        3: begin
          set_regs(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
                   16'(int'($urandom_range(0, 600)) - 300));
          send_gap_max = 0; ready_gap_max = GAP_MAX;
        end
        4: begin
          set_regs(16'($urandom_range(4097, 8191)), 16'($urandom_range(1, 4096)), 16'd0);
          send_gap_max = GAP_MAX; ready_gap_max = GAP_MAX;
        end
        5: begin
          // upper data bits are dropped by the frame size registers
          set_regs(16'($urandom), 16'($urandom), 16'(int'($urandom_range(0, 400)) - 200));
          send_gap_max = 5; ready_gap_max = 5;
        end
        default: begin
          set_regs(16'd640, 16'd480, 16'h7fff);
          send_gap_max = GAP_MAX; ready_gap_max = GAP_MAX;
          count = 30;
        end
      endcase
      for (int i = 0; i < count; i++)
        send_word(draw_word());
    end
  endtask

  // output side: long hold-offs first, then a fresh stall after every word
  initial begin : drive_ready
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (ready_wait > 0) begin
        ready_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_boxes
    box_t want;
    if (!rst && out_valid && out_ready) begin
      ready_wait = (ready_gap_max > 0) ? int'($urandom_range(0, ready_gap_max)) : 0;
      boxes_seen++;
      if (boxes_due.size() == 0) begin
        report_error("unexpected box, anchor_index", -1, anchor_index);
      end else begin
        want = boxes_due.pop_front();
        if (anchor_index !== want.idx) report_error("anchor_index", want.idx, anchor_index);
        if (box_left !== want.left) report_error("box_left", want.left, box_left);
        if (box_top !== want.top) report_error("box_top", want.top, box_top);
        if (box_width !== want.wid) report_error("box_width", want.wid, box_width);
        if (box_height !== want.hgt) report_error("box_height", want.hgt, box_height);
        if (score_logit !== want.score)
          report_error("score_logit", want.score, score_logit);
      end
    end
  end

  initial begin : run_tests
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_field_extremes();
    test_grid_walk();
    test_backpressure();
    test_random();
    settle();
    repeat (20) @(posedge clk);
    if (boxes_due.size() != 0)
      report_error("boxes still outstanding", 0, boxes_due.size());
    $display("covered %0d anchor words across %0d frame wraps and %0d register writes",
             words_sent, frame_wraps, reg_writes);
    $display("compared %0d boxes, %0d errors", boxes_seen, err_count);
    if (err_count == 0) begin
      $display("ssd_anchor_box_decoder_core_tb: done, clean");
    end else begin
      $display("ssd_anchor_box_decoder_core_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("ssd_anchor_box_decoder_core_tb: done, errors");
    $finish;
  end

endmodule
